// ----- rtl/pngpk_pkg.sv -----
// Shared types, register codes and arithmetic constants for the PNG scanline packer.
package pngpk_pkg;

    // Register indexes on the configuration channel
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_DEPTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd2;

    // Register widths and reset values
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned DEPTH_W = 4;
    localparam int unsigned WIDTH_W = 13;
    localparam logic [MODE_W-1:0]  MODE_RESET  = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd4;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1;

    // Colour mode codes
    localparam logic [MODE_W-1:0] MODE_GREY       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRUECOLOR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INDEXED    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GREY_ALPHA = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TC_ALPHA   = 3'd4;

    // Sample depth codes
    localparam logic [DEPTH_W-1:0] DEPTH_1 = 4'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_2 = 4'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_4 = 4'd4;

    // Luma coefficients, 16-bit fixed point; they sum to 65536
    localparam int unsigned LUMA_W = 24;
    localparam logic [LUMA_W-1:0] LUMA_COEF_R = 24'd19595;
    localparam logic [LUMA_W-1:0] LUMA_COEF_G = 24'd38469;
    localparam logic [LUMA_W-1:0] LUMA_COEF_B = 24'd7472;

    // floor(x/17) for x below 256 equals (x*241) >> 12
    localparam logic [15:0] DIV17_RECIP = 16'd241;
    localparam logic [7:0]  THIRD_1     = 8'd85;
    localparam logic [7:0]  THIRD_2     = 8'd170;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    localparam logic [7:0] FILTER_NONE = 8'h00;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LUMA_G,
        ST_LUMA_B,
        ST_SCALE,
        ST_PACK,
        ST_FILTER,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_PACKED,
        ST_ALPHA
    } state_t;

    typedef enum logic [2:0] {
        SEL_FILTER,
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE,
        SEL_ALPHA,
        SEL_PACKED
    } byte_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      luma_g;
        logic      luma_b;
        logic      scale;
        logic      pack;
        logic      emit;
        logic      last;
        byte_sel_t sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              start;
        logic              flush;
        logic              out_free;
    } status_t;

    function automatic logic is_truecolor(input logic [MODE_W-1:0] mode);
        return (mode == MODE_TRUECOLOR) || (mode == MODE_TC_ALPHA);
    endfunction

    function automatic logic is_grey(input logic [MODE_W-1:0] mode);
        return (mode == MODE_GREY) || (mode == MODE_GREY_ALPHA);
    endfunction

endpackage

// ----- rtl/pngpk_ctrl.sv -----
// Controller state machine: sequences luma, packing and byte emission per pixel.
module pngpk_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pngpk_pkg::status_t status,
    output pngpk_pkg::cmd_t   cmd
);
    import pngpk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_FILTER;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    priority if (is_grey(status.mode)) begin
                        state_next = ST_LUMA_G;
                    end else if (status.mode == MODE_INDEXED) begin
                        state_next = ST_PACK;
                    end else if (is_truecolor(status.mode)) begin
                        state_next = ST_FILTER;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LUMA_G: begin
                cmd.luma_g = 1'b1;
                state_next = ST_LUMA_B;
            end
            ST_LUMA_B: begin
                cmd.luma_b = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_PACK;
            end
            ST_PACK: begin
                cmd.pack   = 1'b1;
                state_next = ST_FILTER;
            end
            ST_FILTER: begin
                // filter byte only at the start of a row
                if (!status.start || status.out_free) begin
                    cmd.emit = status.start;
                    cmd.last = !is_truecolor(status.mode) && !status.flush;
                    cmd.sel  = SEL_FILTER;
                    priority if (is_truecolor(status.mode)) begin
                        state_next = ST_RED;
                    end else if (status.flush) begin
                        state_next = ST_PACKED;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RED: begin
                cmd.sel = SEL_RED;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_GREEN;
                end
            end
            ST_GREEN: begin
                cmd.sel = SEL_GREEN;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_BLUE;
                end
            end
            ST_BLUE: begin
                cmd.sel  = SEL_BLUE;
                cmd.last = (status.mode == MODE_TRUECOLOR);
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = (status.mode == MODE_TC_ALPHA) ? ST_ALPHA : ST_IDLE;
                end
            end
            ST_PACKED: begin
                cmd.sel  = SEL_PACKED;
                cmd.last = (status.mode != MODE_GREY_ALPHA);
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = (status.mode == MODE_GREY_ALPHA) ? ST_ALPHA : ST_IDLE;
                end
            end
            ST_ALPHA: begin
                cmd.sel  = SEL_ALPHA;
                cmd.last = 1'b1;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/pngpk_datapath.sv -----
// Datapath: configuration registers, luma MAC, depth scaling, bit packer and output register.
module pngpk_datapath #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [pngpk_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pngpk_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [39:0]                           s_tdata,
    input  pngpk_pkg::cmd_t                       cmd,
    output pngpk_pkg::status_t                    status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,
    output logic                                  m_tlast
);
    import pngpk_pkg::*;

    // widest row the width register can express caps the column counter
    localparam int unsigned WIDTH_MAX_CODE = (1 << WIDTH_W) - 1;
    localparam int unsigned EFF_MAX = (MAX_WIDTH > WIDTH_MAX_CODE) ? WIDTH_MAX_CODE : MAX_WIDTH;
    localparam int unsigned CW = $clog2(EFF_MAX + 1);

    logic [MODE_W-1:0]  color_mode_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [WIDTH_W-1:0] image_width_reg;

    logic [CW-1:0] col_reg;
    logic [7:0]    acc_reg;
    logic [2:0]    slot_reg;
    logic          start_reg;
    logic          flush_reg;
    logic [7:0]    packed_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic [7:0]        alpha_reg;
    logic [7:0]        red_reg;
    logic [LUMA_W-1:0] luma_reg;
    logic [7:0]        sample_reg;

    logic [CW-1:0] w_eff;
    logic          col_over;
    logic [CW-1:0] col_plus;
    logic          row_end;
    logic [1:0]    dlog;
    logic          mode_valid;
    logic [3:0]    slot_inc;
    logic [3:0]    used_bits;
    logic [3:0]    shift;
    logic          byte_full;
    logic [7:0]    packed_val;
    logic [7:0]    luma8;
    logic [15:0]   div17_prod;
    logic [7:0]    scaled;
    logic [7:0]    byte_mux;
    logic          cfg_hit;

    // effective row width: zero acts as one, clamp to the maximum
    always_comb begin
        priority if (image_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (image_width_reg > WIDTH_W'(EFF_MAX)) begin
            w_eff = CW'(EFF_MAX);
        end else begin
            w_eff = CW'(image_width_reg);
        end
    end

    assign col_over   = (col_reg >= w_eff);
    assign col_plus   = col_reg + CW'(1);
    assign row_end    = (col_plus >= w_eff);
    assign mode_valid = (color_mode_reg <= MODE_TC_ALPHA);

    // log2 of the sample depth; anything but 1, 2, 4 in grey or indexed is 8
    always_comb begin
        dlog = 2'd3;
        if ((color_mode_reg == MODE_GREY) || (color_mode_reg == MODE_INDEXED)) begin
            priority if (depth_reg == DEPTH_1) begin
                dlog = 2'd0;
            end else if (depth_reg == DEPTH_2) begin
                dlog = 2'd1;
            end else if (depth_reg == DEPTH_4) begin
                dlog = 2'd2;
            end else begin
                dlog = 2'd3;
            end
        end
    end

    assign slot_inc   = {1'b0, slot_reg} + 4'd1;
    assign used_bits  = slot_inc << dlog;
    assign shift      = 4'd8 - used_bits;
    assign byte_full  = (used_bits >= 4'd8);
    // index bits above the slot are not masked: they OR into earlier slots
    assign packed_val = acc_reg | (sample_reg << shift);

    // luma scaled to (2^depth - 1)/255
    assign luma8      = luma_reg[LUMA_W-1:16];
    assign div17_prod = {8'd0, luma8} * DIV17_RECIP;
    always_comb begin
        unique case (dlog)
            2'd0: scaled = {7'd0, (luma8 == FULL_SCALE)};
            2'd1: begin
                priority if (luma8 == FULL_SCALE) begin
                    scaled = 8'd3;
                end else if (luma8 >= THIRD_2) begin
                    scaled = 8'd2;
                end else if (luma8 >= THIRD_1) begin
                    scaled = 8'd1;
                end else begin
                    scaled = 8'd0;
                end
            end
            2'd2:    scaled = {4'd0, div17_prod[15:12]};
            default: scaled = luma8;
        endcase
    end

    always_comb begin
        unique case (cmd.sel)
            SEL_FILTER: byte_mux = FILTER_NONE;
            SEL_RED:    byte_mux = red_reg;
            SEL_GREEN:  byte_mux = green_reg;
            SEL_BLUE:   byte_mux = blue_reg;
            SEL_ALPHA:  byte_mux = alpha_reg;
            SEL_PACKED: byte_mux = packed_reg;
            default:    byte_mux = FILTER_NONE;
        endcase
    end

    assign cfg_hit = cfg_valid && ((cfg_index == REG_COLOR_MODE) ||
                                   (cfg_index == REG_BIT_DEPTH) ||
                                   (cfg_index == REG_IMAGE_WIDTH));

    // pixel and arithmetic payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_reg    <= s_tdata[15:8];
            green_reg  <= s_tdata[23:16];
            blue_reg   <= s_tdata[31:24];
            alpha_reg  <= s_tdata[39:32];
            luma_reg   <= LUMA_W'(s_tdata[15:8]) * LUMA_COEF_R;
            sample_reg <= s_tdata[7:0];
        end
        if (cmd.luma_g) begin
            luma_reg <= luma_reg + LUMA_W'(green_reg) * LUMA_COEF_G;
        end
        if (cmd.luma_b) begin
            luma_reg <= luma_reg + LUMA_W'(blue_reg) * LUMA_COEF_B;
        end
        if (cmd.scale) begin
            sample_reg <= scaled;
        end
        if (cmd.pack) begin
            packed_reg <= packed_val;
        end
        if (cmd.emit) begin
            out_byte_reg <= byte_mux;
            out_last_reg <= cmd.last;
        end
    end

    // configuration, row state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg  <= MODE_RESET;
            depth_reg       <= DEPTH_RESET;
            image_width_reg <= WIDTH_RESET;
            col_reg         <= '0;
            acc_reg         <= '0;
            slot_reg        <= '0;
            start_reg       <= 1'b0;
            flush_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_hit) begin
                unique case (cfg_index)
                    REG_COLOR_MODE: color_mode_reg  <= cfg_data[MODE_W-1:0];
                    REG_BIT_DEPTH:  depth_reg       <= cfg_data[DEPTH_W-1:0];
                    default:        image_width_reg <= cfg_data[WIDTH_W-1:0];
                endcase
                col_reg  <= '0;
                acc_reg  <= '0;
                slot_reg <= '0;
            end
            if (cmd.load && mode_valid) begin
                start_reg <= (col_reg == '0) || col_over;
                if (is_truecolor(color_mode_reg)) begin
                    // truecolor advances the column straight away
                    if (col_over || row_end) begin
                        col_reg <= '0;
                    end else begin
                        col_reg <= col_plus;
                    end
                    if (col_over || row_end) begin
                        acc_reg  <= '0;
                        slot_reg <= '0;
                    end
                end else if (col_over) begin
                    col_reg  <= '0;
                    acc_reg  <= '0;
                    slot_reg <= '0;
                end
            end
            if (cmd.pack) begin
                flush_reg <= byte_full || row_end;
                if (byte_full || row_end) begin
                    acc_reg  <= '0;
                    slot_reg <= '0;
                end else begin
                    acc_reg  <= packed_val;
                    slot_reg <= slot_inc[2:0];
                end
                col_reg <= row_end ? '0 : col_plus;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.mode     = color_mode_reg;
    assign status.start    = start_reg;
    assign status.flush    = flush_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/png_scanline_pixel_packer.sv -----
// PNG scanline packer: one pixel per input beat in, raw filter-None scanline bytes out.
//
// Each input beat carries one pixel; the block emits the bytes of the raw PNG
// scanline stream, one per output beat, starting every row with the filter byte 0x00.
// Indexed mode packs palette indices MSB-first at 1, 2, 4 or 8 bits (indices are
// not masked, so stray high bits land in earlier slots); grey modes form luma as
// (19595*R + 38469*G + 7472*B) >> 16, scale it to the depth and pack it the same
// way; grey-with-alpha adds the alpha byte; truecolor sends R, G, B and, in the
// alpha mode, A. A part-filled byte is flushed at the end of each row. m_tlast
// marks the final byte caused by a pixel. Modes 5 to 7 accept pixels and emit
// nothing. Any write to a listed register starts a new row; write registers only
// while the block is idle. The controller emits one byte per cycle while the
// output is drained, and the luma multiply-accumulate takes one colour product
// per cycle. The output register lets the next pixel be accepted while the last
// byte waits.
module png_scanline_pixel_packer #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pngpk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pngpk_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,  // pixel_index, red, green, blue, alpha
    // byte stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // out_byte
    output logic                              m_tlast   // last_of_run
);
    import pngpk_pkg::*;

    cmd_t    cmd;
    status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    pngpk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pngpk_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // never overwrite a byte the sink has not taken
    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("byte emitted while output register held an untaken beat");

    // no new pixel while bytes of the current one are still being emitted
    a_emit_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_tready)
        else $error("pixel accepted during byte emission");

    // the controller is not ready in the cycle after accepting a pixel in a valid mode
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (status.mode <= MODE_TC_ALPHA)) |=> !s_tready)
        else $error("controller idle right after accepting a pixel");
`endif

endmodule
